>>> rtl/bep_pkg.sv
// Shared types and constants of the backlight effect PWM block.
// Used by bep_pwm and backlight_effect_pwm; depends on nothing.

package bep_pkg;

  localparam int unsigned LVL_W   = 5;  // brightness level width
  localparam int unsigned POS_W   = 5;  // PWM cycle position width
  localparam int unsigned ACC_W   = 8;  // distributing counter width
  localparam int unsigned CFG_W   = 8;  // widest configuration register
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_W   = 16; // packed result width, whole bytes

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_REACT  = 3'd1,
    CMD_NEXT   = 3'd2,
    CMD_DIMMER = 3'd3,
    CMD_USB    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STATIC    = 2'd0,
    MODE_BREATHING = 2'd1,
    MODE_REACTIVE  = 2'd2,
    MODE_ERODE     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_DIMMER_STEP = 3'd0,
    REG_WRAP_MASK   = 3'd1,
    REG_MIN_LEVEL   = 3'd2,
    REG_PEAK        = 3'd3,
    REG_TROUGH      = 3'd4,
    REG_DELAY       = 3'd5,
    REG_ERODE_STEP  = 3'd6,
    REG_MOD_MASK    = 3'd7
  } reg_idx_e;

endpackage

>>> rtl/backlight_effect_pwm.sv
// Top level of the backlight effect PWM block: event stream in, PWM/level
// result stream out. Depends on bep_pkg and bep_pwm.
//
// Usage: each item on the slave stream is one event, its kind in tuser
// (0 tick, 1 key react, 2 next mode, 3 dimmer step, 4 USB status) and the
// USB host flag in tdata bit 0. Every item gives exactly one result item on
// the master stream: indicator and gated backlight PWM bits, both levels and
// the current mode.
// Throughput is one item per cycle while the receiver takes results. An
// accepted item sits in the input register, is processed against the block
// state and lands in the result register, from which it is presented.
// The rate is set by the combinational state update between those registers.
// Reset clears the PWM counters and prescaler, sets both levels to full,
// selects static mode, drops the host flag and loads the register defaults.
// When the receiver stalls the result holds; one more item is taken into the
// input register, after which tready drops until the result is taken.
// Configuration writes (cfg_we_i) take effect at once and belong to idle time.

module backlight_effect_pwm #(
  parameter int unsigned LEVELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] usb_active, rest zero
  input  logic [2:0]                    s_axis_tuser,  // [2:0] cmd
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] indicator_on, [1] backlight_on, [6:2] indicator_level,
  // [11:7] backlight_level, [13:12] current_mode, [15:14] zero
  output logic [bep_pkg::OUT_W-1:0]     m_axis_tdata,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bep_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bep_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned LW = bep_pkg::LVL_W;
  localparam int unsigned AW = bep_pkg::ACC_W;
  localparam int unsigned PW = bep_pkg::POS_W;

  // configuration registers
  logic [3:0]    dstep_q;
  logic [LW-1:0] wmask_q, minlvl_q, peak_q, trough_q, estep_q;
  logic [7:0]    delay_q, modmask_q;

  // input register
  logic       in_vld_q;
  logic [2:0] cmd_q;
  logic       usb_q;

  // block state
  logic [PW-1:0]       pos_q, pos_d;
  logic [AW-1:0]       iacc_q, iacc_d, bacc_q, bacc_d;
  logic [LW-1:0]       ilvl_q, ilvl_d, blvl_q, blvl_d;
  bep_pkg::mode_e      mode_q, mode_d;
  logic                rise_q, rise_d;
  logic [7:0]          presc_q, presc_d;
  logic                iout_q, iout_d, bout_q, bout_d;
  logic                host_q, host_d;

  // result register
  logic                      out_vld_q;
  logic [bep_pkg::OUT_W-1:0] out_q;

  logic adv;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstep_q   <= 4'd2;
      wmask_q   <= LW'(15);
      minlvl_q  <= LW'(1);
      peak_q    <= LW'(12);
      trough_q  <= LW'(2);
      delay_q   <= 8'd10;
      estep_q   <= LW'(4);
      modmask_q <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bep_pkg::REG_DIMMER_STEP: dstep_q   <= cfg_wdata_i[3:0];
        bep_pkg::REG_WRAP_MASK:   wmask_q   <= cfg_wdata_i[LW-1:0];
        bep_pkg::REG_MIN_LEVEL:   minlvl_q  <= cfg_wdata_i[LW-1:0];
        bep_pkg::REG_PEAK:        peak_q    <= cfg_wdata_i[LW-1:0];
        bep_pkg::REG_TROUGH:      trough_q  <= cfg_wdata_i[LW-1:0];
        bep_pkg::REG_DELAY:       delay_q   <= cfg_wdata_i;
        bep_pkg::REG_ERODE_STEP:  estep_q   <= cfg_wdata_i[LW-1:0];
        bep_pkg::REG_MOD_MASK:    modmask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---- tick path -----------------------------------------------------------
  logic [PW-1:0] pos_inc, t_pos;
  logic [AW-1:0] t_iacc, t_bacc;
  logic [7:0]    presc_inc, t_presc;
  logic [LW-1:0] t_blvl;
  logic          t_rise;
  logic          t_ion, t_bon;
  logic [AW-1:0] t_iacc_n, t_bacc_n;

  always_comb begin
    pos_inc = pos_q + PW'(1);
    if (pos_inc > PW'(LEVELS)) begin
      t_pos  = PW'(1);
      t_iacc = '0;
      t_bacc = '0;
    end else begin
      t_pos  = pos_inc;
      t_iacc = iacc_q;
      t_bacc = bacc_q;
    end
  end

  always_comb begin
    presc_inc = presc_q + 8'd1;
    t_presc   = presc_inc;
    t_blvl    = blvl_q;
    t_rise    = rise_q;
    if (presc_inc >= delay_q) begin
      t_presc = '0;
      case (mode_q)
        bep_pkg::MODE_BREATHING: begin
          if (rise_q) begin
            if (blvl_q != '1) t_blvl = blvl_q + LW'(1);
            if (t_blvl >= peak_q) t_rise = 1'b0;
          end else begin
            if (blvl_q != '0) t_blvl = blvl_q - LW'(1);
            if (t_blvl <= trough_q) t_rise = 1'b1;
          end
        end
        bep_pkg::MODE_REACTIVE: begin
          if (blvl_q > trough_q) t_blvl = blvl_q - LW'(1);
        end
        bep_pkg::MODE_ERODE: begin
          if (blvl_q < LW'(LEVELS)) t_blvl = blvl_q + LW'(1);
        end
        default: ;
      endcase
    end
  end

  bep_pwm #(.LEVELS(LEVELS)) u_ind_pwm (
    .pos_i   (t_pos),
    .level_i (ilvl_q),
    .accum_i (t_iacc),
    .mask_i  ({AW{1'b1}}),
    .on_o    (t_ion),
    .accum_o (t_iacc_n)
  );

  bep_pwm #(.LEVELS(LEVELS)) u_bl_pwm (
    .pos_i   (t_pos),
    .level_i (t_blvl),
    .accum_i (t_bacc),
    .mask_i  (t_rise ? modmask_q : {AW{1'b1}}),
    .on_o    (t_bon),
    .accum_o (t_bacc_n)
  );

  // ---- other events --------------------------------------------------------
  logic [LW-1:0]  dim_lvl;
  logic [LW-1:0]  sum_lvl;
  bep_pkg::mode_e mode_nx;

  assign sum_lvl = ilvl_q + LW'(dstep_q);
  assign dim_lvl = (ilvl_q >= LW'(LEVELS)) ? minlvl_q : (sum_lvl & wmask_q);
  assign mode_nx = bep_pkg::mode_e'(2'(mode_q + 2'd1));

  always_comb begin
    pos_d   = pos_q;
    iacc_d  = iacc_q;
    bacc_d  = bacc_q;
    ilvl_d  = ilvl_q;
    blvl_d  = blvl_q;
    mode_d  = mode_q;
    rise_d  = rise_q;
    presc_d = presc_q;
    iout_d  = iout_q;
    bout_d  = bout_q;
    host_d  = host_q;
    if (adv) begin
      case (cmd_q)
        bep_pkg::CMD_TICK: begin
          pos_d   = t_pos;
          iacc_d  = t_iacc_n;
          bacc_d  = t_bacc_n;
          presc_d = t_presc;
          blvl_d  = t_blvl;
          rise_d  = t_rise;
          iout_d  = t_ion;
          bout_d  = t_bon;
        end
        bep_pkg::CMD_REACT: begin
          if (mode_q == bep_pkg::MODE_REACTIVE) begin
            blvl_d = peak_q;
          end else if (mode_q == bep_pkg::MODE_ERODE) begin
            if (blvl_q > estep_q) blvl_d = blvl_q - estep_q;
            else if (blvl_q != '0) blvl_d = blvl_q - LW'(1);
          end
        end
        bep_pkg::CMD_NEXT: begin
          mode_d = mode_nx;
          case (mode_nx)
            bep_pkg::MODE_STATIC:    blvl_d = ilvl_q;
            bep_pkg::MODE_BREATHING: blvl_d = trough_q;
            bep_pkg::MODE_REACTIVE: begin
              blvl_d = trough_q;
              rise_d = 1'b0;
            end
            default: begin
              blvl_d = LW'(LEVELS);
              rise_d = 1'b1;
            end
          endcase
        end
        bep_pkg::CMD_DIMMER: begin
          ilvl_d = dim_lvl;
          if (mode_q == bep_pkg::MODE_STATIC) blvl_d = dim_lvl;
        end
        bep_pkg::CMD_USB: host_d = usb_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
      iacc_q    <= '0;
      bacc_q    <= '0;
      ilvl_q    <= LW'(LEVELS);
      blvl_q    <= LW'(LEVELS);
      mode_q    <= bep_pkg::MODE_STATIC;
      rise_q    <= 1'b0;
      presc_q   <= '0;
      iout_q    <= 1'b0;
      bout_q    <= 1'b0;
      host_q    <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      pos_q   <= pos_d;
      iacc_q  <= iacc_d;
      bacc_q  <= bacc_d;
      ilvl_q  <= ilvl_d;
      blvl_q  <= blvl_d;
      mode_q  <= mode_d;
      rise_q  <= rise_d;
      presc_q <= presc_d;
      iout_q  <= iout_d;
      bout_q  <= bout_d;
      host_q  <= host_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q <= s_axis_tuser;
      usb_q <= s_axis_tdata[0];
    end
    if (adv) begin
      out_q <= {2'b00, mode_d, blvl_d, ilvl_d, host_d & bout_d, iout_d};
    end
  end

  // ---- assertions ----------------------------------------------------------
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(LEVELS))
    else $error("cycle position beyond LEVELS");

  a_tick_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cmd_q == bep_pkg::CMD_TICK) |=> (pos_q != '0))
    else $error("tick left cycle position at zero");

  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && cmd_q == bep_pkg::CMD_NEXT) |=> $stable(mode_q))
    else $error("mode changed without a next-mode item");

  a_static_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cmd_q == bep_pkg::CMD_DIMMER && mode_q == bep_pkg::MODE_STATIC)
      |=> (blvl_q == ilvl_q))
    else $error("static backlight did not follow the indicator level");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("processed item gave no result");

endmodule

>>> rtl/bep_pwm.sv
// One distributing PWM channel: turns a level and the cycle position into an
// on/off bit and the next counter value. Depends on bep_pkg.

module bep_pwm #(
  parameter int unsigned LEVELS = 16
) (
  input  logic [bep_pkg::POS_W-1:0] pos_i,
  input  logic [bep_pkg::LVL_W-1:0] level_i,
  input  logic [bep_pkg::ACC_W-1:0] accum_i,
  input  logic [bep_pkg::ACC_W-1:0] mask_i,
  output logic                      on_o,
  output logic [bep_pkg::ACC_W-1:0] accum_o
);

  localparam int unsigned PROD_W = bep_pkg::POS_W + bep_pkg::LVL_W;

  logic [PROD_W-1:0]         prod;
  logic [bep_pkg::ACC_W-1:0] req;

  assign prod = PROD_W'(pos_i) * PROD_W'(level_i);
  assign req  = prod[bep_pkg::ACC_W-1:0] & mask_i;

  always_comb begin
    on_o    = 1'b0;
    accum_o = accum_i;
    if (level_i >= bep_pkg::LVL_W'(LEVELS)) begin
      on_o = 1'b1;
    end else if (req > accum_i) begin
      on_o    = 1'b1;
      accum_o = accum_i + bep_pkg::ACC_W'(LEVELS);
    end
  end

endmodule

>>> tb/tb_backlight_effect_pwm.sv
// Self-checking testbench for backlight_effect_pwm: directed event table, then random
// phases under several register settings, checked against typed rows or a cycle-free state predictor.
// Depends on bep_pkg and the backlight_effect_pwm RTL only.

module tb_backlight_effect_pwm;

  localparam int unsigned LEVELS      = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned DIR_ROWS    = 25;

  // command codes the block leaves unused
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  // result item as laid out on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [1:0]     pad;
    bep_pkg::mode_e mode;
    logic [4:0]     bl_lvl;
    logic [4:0]     ind_lvl;
    logic           bl_on;
    logic           ind_on;
  } status_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       usb;
    logic       typed;
    status_t    want;
  } event_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;  // [0] usb_active
  logic [2:0]                    s_axis_tuser = '0;  // [2:0] cmd
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bep_pkg::OUT_W-1:0]     m_axis_tdata;       // see status_t
  logic                          cfg_we_i = 1'b0;
  logic [bep_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [bep_pkg::CFG_W-1:0]     cfg_wdata_i = '0;

  // predicted block state
  logic [4:0]     cyc_pos;
  logic [7:0]     ind_acc, bl_acc;
  logic [4:0]     ind_lvl, bl_lvl;
  bep_pkg::mode_e fx_mode;
  logic           rising;
  logic [7:0]     prescale;
  logic           ind_out, bl_out, host_ok;
  logic [7:0]     cfg_reg [8];

  int unsigned reg_width [8] = '{4, 5, 5, 5, 5, 8, 5, 8};
  int unsigned reg_lo    [8] = '{0, 0, 0, 0, 0, 1, 0, 0};
  int unsigned reg_hi    [8] = '{15, 31, 16, 16, 16, 255, 16, 255};
  int unsigned reg_init  [8] = '{2, 15, 1, 12, 2, 10, 4, 255};

  status_t     pending_status_q [$];
  event_row_t  dir_rows [DIR_ROWS];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  backlight_effect_pwm #(
    .LEVELS(LEVELS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void reset_model();
    cyc_pos  = '0;
    ind_acc  = '0;
    bl_acc   = '0;
    ind_lvl  = 5'(LEVELS);
    bl_lvl   = 5'(LEVELS);
    fx_mode  = bep_pkg::MODE_STATIC;
    rising   = 1'b0;
    prescale = '0;
    ind_out  = 1'b0;
    bl_out   = 1'b0;
    host_ok  = 1'b0;
    for (int i = 0; i < 8; i++) cfg_reg[i] = 8'(reg_init[i]);
  endfunction

  function automatic status_t mk_status(logic ind_on, logic bl_on, int unsigned ind,
                                        int unsigned bl, bep_pkg::mode_e mode);
    status_t s;
    s = '0;
    s.ind_on  = ind_on;
    s.bl_on   = bl_on;
    s.ind_lvl = 5'(ind);
    s.bl_lvl  = 5'(bl);
    s.mode    = mode;
    return s;
  endfunction

  // one bit of a distributing PWM counter; full level or more is steady on
  function automatic logic pwm_level_bit(input logic [4:0] lvl, inout logic [7:0] acc,
                                         input logic masked);
    int unsigned prod;
    logic [7:0]  req;
    if (lvl >= LEVELS) return 1'b1;
    prod = cyc_pos * lvl;
    req  = prod[7:0];
    if (masked) req &= cfg_reg[bep_pkg::REG_MOD_MASK];
    if (req > acc) begin
      acc = acc + 8'(LEVELS);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void step_effect();
    prescale = prescale + 8'd1;
    if (prescale < cfg_reg[bep_pkg::REG_DELAY]) return;
    prescale = '0;
    case (fx_mode)
      bep_pkg::MODE_BREATHING: begin
        if (rising) begin
          if (bl_lvl < 5'd31) bl_lvl = bl_lvl + 5'd1;
          if (bl_lvl >= cfg_reg[bep_pkg::REG_PEAK]) rising = 1'b0;
        end else begin
          if (bl_lvl > 5'd0) bl_lvl = bl_lvl - 5'd1;
          if (bl_lvl <= cfg_reg[bep_pkg::REG_TROUGH]) rising = 1'b1;
        end
      end
      bep_pkg::MODE_REACTIVE: begin
        if (bl_lvl > cfg_reg[bep_pkg::REG_TROUGH]) bl_lvl = bl_lvl - 5'd1;
      end
      bep_pkg::MODE_ERODE: begin
        if (bl_lvl < LEVELS) bl_lvl = bl_lvl + 5'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic status_t predict_status(logic [2:0] cmd, logic usb);
    logic [7:0] sum;
    case (cmd)
      bep_pkg::CMD_TICK: begin
        cyc_pos = cyc_pos + 5'd1;
        if (cyc_pos > LEVELS) begin
          cyc_pos = 5'd1;
          ind_acc = '0;
          bl_acc  = '0;
        end
        ind_out = pwm_level_bit(ind_lvl, ind_acc, 1'b0);
        step_effect();
        bl_out = pwm_level_bit(bl_lvl, bl_acc, rising);
      end
      bep_pkg::CMD_REACT: begin
        if (fx_mode == bep_pkg::MODE_REACTIVE) begin
          bl_lvl = cfg_reg[bep_pkg::REG_PEAK][4:0];
        end else if (fx_mode == bep_pkg::MODE_ERODE) begin
          if (bl_lvl > cfg_reg[bep_pkg::REG_ERODE_STEP]) begin
            bl_lvl = bl_lvl - cfg_reg[bep_pkg::REG_ERODE_STEP][4:0];
          end else if (bl_lvl > 5'd0) begin
            bl_lvl = bl_lvl - 5'd1;
          end
        end
      end
      bep_pkg::CMD_NEXT: begin
        fx_mode = bep_pkg::mode_e'(fx_mode + 2'd1);
        case (fx_mode)
          bep_pkg::MODE_STATIC:    bl_lvl = ind_lvl;
          bep_pkg::MODE_BREATHING: bl_lvl = cfg_reg[bep_pkg::REG_TROUGH][4:0];
          bep_pkg::MODE_REACTIVE: begin
            bl_lvl = cfg_reg[bep_pkg::REG_TROUGH][4:0];
            rising = 1'b0;
          end
          default: begin
            bl_lvl = 5'(LEVELS);
            rising = 1'b1;
          end
        endcase
      end
      bep_pkg::CMD_DIMMER: begin
        if (ind_lvl >= LEVELS) begin
          ind_lvl = cfg_reg[bep_pkg::REG_MIN_LEVEL][4:0];
        end else begin
          sum     = ind_lvl + cfg_reg[bep_pkg::REG_DIMMER_STEP];
          ind_lvl = sum[4:0] & cfg_reg[bep_pkg::REG_WRAP_MASK][4:0];
        end
        if (fx_mode == bep_pkg::MODE_STATIC) bl_lvl = ind_lvl;
      end
      bep_pkg::CMD_USB: host_ok = usb;
      default: ;
    endcase
    return mk_status(ind_out, host_ok & bl_out, ind_lvl, bl_lvl, fx_mode);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // send one event item; the expectation is the typed one if given, else the prediction
  task automatic push_event(logic [2:0] cmd, logic usb, logic typed, status_t want);
    int unsigned gap;
    status_t     pred;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'b0, usb};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_status(cmd, usb);
    pending_status_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // phase 0 takes every register's low end, phase 1 its high end
  task automatic program_regs(int unsigned phase);
    int unsigned val;
    for (int i = 0; i < 8; i++) begin
      if (phase == 0) val = reg_lo[i];
      else if (phase == 1) val = reg_hi[i];
      else val = $urandom_range(reg_lo[i], reg_hi[i]);
      if (bep_pkg::reg_idx_e'(i) == bep_pkg::REG_DELAY) begin
        if (phase == 2) val = 0;  // prescaler fires on every tick
        else if (phase == 3 || phase == 4) val = $urandom_range(1, 12);
      end
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= 8'(val);
      @(posedge clk_i);
      cfg_reg[i] = 8'(val & ((1 << reg_width[i]) - 1));
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [2:0] random_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return bep_pkg::CMD_TICK;
    if (r < 67) return bep_pkg::CMD_REACT;
    if (r < 74) return bep_pkg::CMD_NEXT;
    if (r < 86) return bep_pkg::CMD_DIMMER;
    if (r < 94) return bep_pkg::CMD_USB;
    return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  initial begin : result_sink
    status_t     got, want;
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = status_t'(m_axis_tdata);
        if (pending_status_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %h", $time, got);
          fail_cnt++;
        end else begin
          want = pending_status_q.pop_front();
          check_field("indicator_on", want.ind_on, got.ind_on);
          check_field("backlight_on", want.bl_on, got.bl_on);
          check_field("indicator_level", want.ind_lvl, got.ind_lvl);
          check_field("backlight_level", want.bl_lvl, got.bl_lvl);
          check_field("current_mode", want.mode, got.mode);
          check_field("padding", 0, got.pad);
        end
        if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
        stall = sink_steady ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    event_row_t row;
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers throughout the directed part
    dir_rows = '{
      '{bep_pkg::CMD_USB,    1'b0, 1'b1, mk_status(0, 0, 16, 16, bep_pkg::MODE_STATIC)},
      '{bep_pkg::CMD_TICK,   1'b0, 1'b1, mk_status(1, 0, 16, 16, bep_pkg::MODE_STATIC)},
      '{bep_pkg::CMD_USB,    1'b1, 1'b1, mk_status(1, 1, 16, 16, bep_pkg::MODE_STATIC)},
      '{bep_pkg::CMD_TICK,   1'b1, 1'b1, mk_status(1, 1, 16, 16, bep_pkg::MODE_STATIC)},
      '{CMD_SPARE_FIRST,     1'b1, 1'b1, mk_status(1, 1, 16, 16, bep_pkg::MODE_STATIC)},
      '{CMD_SPARE_MID,       1'b0, 1'b1, mk_status(1, 1, 16, 16, bep_pkg::MODE_STATIC)},
      '{CMD_SPARE_LAST,      1'b1, 1'b1, mk_status(1, 1, 16, 16, bep_pkg::MODE_STATIC)},
      '{bep_pkg::CMD_DIMMER, 1'b0, 1'b1, mk_status(1, 1, 1, 1, bep_pkg::MODE_STATIC)},
      '{bep_pkg::CMD_DIMMER, 1'b1, 1'b1, mk_status(1, 1, 3, 3, bep_pkg::MODE_STATIC)},
      '{bep_pkg::CMD_TICK,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_REACT,  1'b0, 1'b0, '0},
      '{bep_pkg::CMD_NEXT,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_REACT,  1'b1, 1'b0, '0},
      '{bep_pkg::CMD_TICK,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_TICK,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_NEXT,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_REACT,  1'b0, 1'b0, '0},
      '{bep_pkg::CMD_TICK,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_NEXT,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_REACT,  1'b0, 1'b0, '0},
      '{bep_pkg::CMD_REACT,  1'b0, 1'b0, '0},
      '{bep_pkg::CMD_TICK,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_NEXT,   1'b0, 1'b0, '0},
      '{bep_pkg::CMD_DIMMER, 1'b0, 1'b0, '0},
      '{bep_pkg::CMD_USB,    1'b0, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      push_event(row.cmd, row.usb, row.typed, row.want);
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      program_regs(ph);
      src_steady = ($urandom_range(0, 2) == 0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        logic [2:0] cmd;
        logic       usb;
        // hold off mid-phase until the block has drained
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_idle();
        if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
        cmd = random_cmd();
        usb = (cmd == bep_pkg::CMD_USB) ? ($urandom_range(0, 3) != 0)
                                        : 1'($urandom_range(0, 1));
        push_event(cmd, usb, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_status_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
